### rtl/wssd_pkg.sv
package wssd_pkg;

  // Data path widths and fixed-point layout.
  localparam int DATA_W     = 32;
  localparam int WIN_W      = 5;
  localparam int RUN_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int FRAC_SHIFT = 24;
  localparam int DIV_PRE    = DATA_W - FRAC_SHIFT;
  localparam int DIV_STEPS  = DATA_W;

  // Defaults for the top-level parameters.
  localparam int DEF_HISTORY_DEPTH   = 32;
  localparam int DEF_DISP_REF_FLOOR  = 1;
  localparam int DEF_FORCE_REF_FLOOR = 1;

  // Register reset values.
  localparam logic [WIN_W-1:0]  RST_WINDOW_LEN    = WIN_W'(10);
  localparam logic [RUN_W-1:0]  RST_CONSEC_NEEDED = RUN_W'(1);
  localparam logic [DATA_W-1:0] RST_MIN_TIME      = '0;
  localparam logic [DATA_W-1:0] RST_ABS_TOL       = '0;
  localparam logic [DATA_W-1:0] RST_REL_TOL       = DATA_W'(168);

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LEN    = 3'd0,
    REG_CONSEC_NEEDED = 3'd1,
    REG_MIN_TIME      = 3'd2,
    REG_DISP_ABS_TOL  = 3'd3,
    REG_DISP_REL_TOL  = 3'd4,
    REG_FORCE_ABS_TOL = 3'd5,
    REG_FORCE_REL_TOL = 3'd6
  } cfg_reg_t;

endpackage

### rtl/windowed_steady_state_detector_unit.sv
// Windowed steady-state detector. Each input beat carries a sample time and
// signed Q16.16 displacement and force values, stored in one history RAM.
// The current values are compared with those taken window_len samples
// earlier; the block reports absolute change (Q16.16) and relative change
// (Q8.24, saturating), judges steadiness, counts a run of steady samples and
// latches stopped when the run reaches consec_needed. Every input beat gives
// exactly one output beat. An evaluated sample passes from its accept to the
// next accept through these steps: forming the changes from the RAM read,
// two relative-change quotients from a single shared bit-serial divider
// (a start, 32 steps and a hand-back; a quotient that saturates skips the
// steps), one result step and an idle step that accepts the next beat. A
// sample not evaluated, or arriving after stop, goes from accept straight to
// the result step. The next beat is accepted while a finished result still
// waits on out_stall; that beat then waits in the result stage.
// The history RAM needs no clearing after reset.
module windowed_steady_state_detector_unit #(
  parameter int HISTORY_DEPTH   = wssd_pkg::DEF_HISTORY_DEPTH,
  parameter int DISP_REF_FLOOR  = wssd_pkg::DEF_DISP_REF_FLOOR,
  parameter int FORCE_REF_FLOOR = wssd_pkg::DEF_FORCE_REF_FLOOR
) (
  input  logic                               clk,
  input  logic                               rst,
  // Sample input channel.
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [wssd_pkg::DATA_W-1:0]        sample_time,
  input  logic signed [wssd_pkg::DATA_W-1:0] displacement,
  input  logic signed [wssd_pkg::DATA_W-1:0] force_req,
  // Result output channel.
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               changes_valid,
  output logic [wssd_pkg::DATA_W-1:0]        disp_abs_change,
  output logic [wssd_pkg::DATA_W-1:0]        disp_rel_change,
  output logic [wssd_pkg::DATA_W-1:0]        force_abs_change,
  output logic [wssd_pkg::DATA_W-1:0]        force_rel_change,
  output logic                               steady,
  output logic [wssd_pkg::RUN_W-1:0]         steady_count,
  output logic                               stop_now,
  output logic                               stopped,
  // Configuration write channel.
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [wssd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wssd_pkg::DATA_W-1:0]        cfg_data
);

  import wssd_pkg::*;

  localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int HW = $clog2(HISTORY_DEPTH + 1);
  localparam int CW = (HW > WIN_W) ? HW : WIN_W;
  localparam int SW = ((AW > WIN_W) ? AW : WIN_W) + 1;
  localparam logic [RUN_W-1:0] RUN_MAX = '1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_DIV_D,
    S_DIV_F,
    S_FIN
  } state_t;

  // Signed difference magnitude; always fits in 32 bits.
  function automatic logic [DATA_W-1:0] abs_diff(input logic [DATA_W-1:0] a,
                                                 input logic [DATA_W-1:0] b);
    logic [DATA_W:0] d;
    d = {a[DATA_W-1], a} - {b[DATA_W-1], b};
    return d[DATA_W] ? DATA_W'(~d + 1'b1) : d[DATA_W-1:0];
  endfunction

  // Reference: the larger of the old magnitude and the floor.
  function automatic logic [DATA_W-1:0] ref_of(input logic [DATA_W-1:0] v,
                                               input logic [DATA_W-1:0] flr);
    logic [DATA_W-1:0] m;
    m = v[DATA_W-1] ? (~v + 1'b1) : v;
    return (m < flr) ? flr : m;
  endfunction

  // Configuration registers.
  logic [WIN_W-1:0]  window_len;
  logic [RUN_W-1:0]  consec_needed;
  logic [DATA_W-1:0] min_time;
  logic [DATA_W-1:0] disp_abs_tol;
  logic [DATA_W-1:0] disp_rel_tol;
  logic [DATA_W-1:0] force_abs_tol;
  logic [DATA_W-1:0] force_rel_tol;

  // Control state.
  state_t            state;
  logic [AW-1:0]     write_slot;
  logic [HW-1:0]     samples_held;
  logic [RUN_W-1:0]  steady_run;
  logic              stop_latched;
  logic              eval;
  logic              skip;
  logic              div_start;

  // Working values of the sample in flight.
  logic [DATA_W-1:0] cur_disp;
  logic [DATA_W-1:0] cur_force;
  logic [DATA_W-1:0] dabs;
  logic [DATA_W-1:0] fabs;
  logic [DATA_W-1:0] dref;
  logic [DATA_W-1:0] fref;
  logic [DATA_W-1:0] drel;
  logic [DATA_W-1:0] frel;

  logic                in_accept;
  logic [AW-1:0]       slot_next;
  logic [HW-1:0]       held_next;
  logic                eval_now;
  logic [SW-1:0]       back_diff;
  logic [AW-1:0]       old_addr;
  logic [2*DATA_W-1:0] rd_data;
  logic [DATA_W-1:0]   old_disp;
  logic [DATA_W-1:0]   old_force;
  logic                div_done;
  logic [DATA_W-1:0]   div_quo;
  logic                steady_w;
  logic [RUN_W-1:0]    run_next;
  logic                stop_hit;
  logic                out_free;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;

  // Ring pointer and fill count after this beat is stored.
  assign slot_next = (write_slot == AW'(HISTORY_DEPTH - 1)) ? '0 : write_slot + 1'b1;
  assign held_next = (samples_held < HW'(HISTORY_DEPTH)) ? samples_held + 1'b1
                                                         : samples_held;
  assign eval_now  = !stop_latched && (sample_time >= min_time)
                   && (CW'(held_next) > CW'(window_len));

  // Slot of the reference sample, wrapped around the ring.
  assign back_diff = SW'(write_slot) - SW'(window_len);
  assign old_addr  = (SW'(write_slot) >= SW'(window_len))
                   ? AW'(back_diff) : AW'(back_diff + SW'(HISTORY_DEPTH));

  // A window of zero refers to the sample just written.
  assign old_disp  = (window_len == '0) ? cur_disp  : rd_data[2*DATA_W-1:DATA_W];
  assign old_force = (window_len == '0) ? cur_force : rd_data[DATA_W-1:0];

  // Steadiness and run update for the result stage.
  assign steady_w = eval && ((dabs <= disp_abs_tol) || (drel <= disp_rel_tol))
                  && ((fabs <= force_abs_tol) || (frel <= force_rel_tol));
  assign run_next = steady_w ? ((steady_run == RUN_MAX) ? steady_run : steady_run + 1'b1)
                             : '0;
  assign stop_hit = run_next >= consec_needed;

  wssd_ram #(
    .WIDTH (2 * DATA_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (in_accept && !stop_latched),
    .wr_addr (write_slot),
    .wr_data ({displacement, force_req}),
    .rd_en   (in_accept),
    .rd_addr (old_addr),
    .rd_data (rd_data)
  );

  wssd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ((state == S_DIV_F) ? fabs : dabs),
    .divisor  ((state == S_DIV_F) ? fref : dref),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_len    <= RST_WINDOW_LEN;
      consec_needed <= RST_CONSEC_NEEDED;
      min_time      <= RST_MIN_TIME;
      disp_abs_tol  <= RST_ABS_TOL;
      disp_rel_tol  <= RST_REL_TOL;
      force_abs_tol <= RST_ABS_TOL;
      force_rel_tol <= RST_REL_TOL;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WINDOW_LEN:    window_len    <= cfg_data[WIN_W-1:0];
        REG_CONSEC_NEEDED: consec_needed <= cfg_data[RUN_W-1:0];
        REG_MIN_TIME:      min_time      <= cfg_data;
        REG_DISP_ABS_TOL:  disp_abs_tol  <= cfg_data;
        REG_DISP_REL_TOL:  disp_rel_tol  <= cfg_data;
        REG_FORCE_ABS_TOL: force_abs_tol <= cfg_data;
        REG_FORCE_REL_TOL: force_rel_tol <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer: accept, read the reference, two divides, then the result beat; unevaluated samples skip to the result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      write_slot   <= '0;
      samples_held <= '0;
      steady_run   <= '0;
      stop_latched <= 1'b0;
      div_start    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      // The divider starts after the read stage and after the first quotient.
      div_start <= (state == S_READ) || ((state == S_DIV_D) && div_done);
      if ((state == S_FIN) && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            cur_disp  <= displacement;
            cur_force <= force_req;
            eval      <= eval_now;
            skip      <= stop_latched;
            if (!stop_latched) begin
              write_slot   <= slot_next;
              samples_held <= held_next;
            end
            state <= eval_now ? S_READ : S_FIN;
          end
        end
        S_READ: begin
          dabs      <= abs_diff(cur_disp, old_disp);
          fabs      <= abs_diff(cur_force, old_force);
          dref      <= ref_of(old_disp, DATA_W'(DISP_REF_FLOOR));
          fref      <= ref_of(old_force, DATA_W'(FORCE_REF_FLOOR));
          state     <= S_DIV_D;
        end
        S_DIV_D: begin
          if (div_done) begin
            drel      <= div_quo;
            state     <= S_DIV_F;
          end
        end
        S_DIV_F: begin
          if (div_done) begin
            frel  <= div_quo;
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            changes_valid    <= eval;
            disp_abs_change  <= eval ? dabs : '0;
            disp_rel_change  <= eval ? drel : '0;
            force_abs_change <= eval ? fabs : '0;
            force_rel_change <= eval ? frel : '0;
            if (skip) begin
              steady       <= 1'b0;
              steady_count <= steady_run;
              stop_now     <= 1'b0;
              stopped      <= 1'b1;
            end else begin
              steady       <= steady_w;
              steady_run   <= run_next;
              steady_count <= run_next;
              stop_now     <= stop_hit;
              stopped      <= stop_hit;
              if (stop_hit) begin
                stop_latched <= 1'b1;
              end
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/wssd_ram.sv
module wssd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/wssd_div.sv
module wssd_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [wssd_pkg::DATA_W-1:0] dividend,
  input  logic [wssd_pkg::DATA_W-1:0] divisor,
  output logic                       done,
  output logic [wssd_pkg::DATA_W-1:0] quotient
);

  import wssd_pkg::*;

  typedef enum logic {
    D_IDLE,
    D_RUN
  } div_state_t;

  localparam int CNT_W = $clog2(DIV_STEPS);

  div_state_t        state;
  logic [DATA_W-1:0] rem;
  logic [CNT_W-1:0]  cnt;
  logic [DATA_W:0]   trial;
  logic              fits;
  logic              ovf;

  // The quotient overflows 32 bits when the upper dividend part reaches the divisor.
  assign ovf   = DATA_W'(dividend >> DIV_PRE) >= divisor;
  assign trial = {rem, quotient[DATA_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  // Restoring division, one quotient bit per cycle. The quotient register also
  // holds the dividend bits still to be shifted in.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        D_IDLE: begin
          if (start) begin
            if (ovf) begin
              quotient <= '1;
              done     <= 1'b1;
            end else begin
              rem      <= DATA_W'(dividend >> DIV_PRE);
              quotient <= dividend << FRAC_SHIFT;
              cnt      <= '0;
              state    <= D_RUN;
            end
          end
        end
        D_RUN: begin
          rem      <= fits ? DATA_W'(trial - {1'b0, divisor}) : trial[DATA_W-1:0];
          quotient <= {quotient[DATA_W-2:0], fits};
          cnt      <= cnt + 1'b1;
          if (cnt == CNT_W'(DIV_STEPS - 1)) begin
            done  <= 1'b1;
            state <= D_IDLE;
          end
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule
